// ===== src/varot_pkg.sv =====
// Package for the vector axis rotation core: widths, axis codes, the CORDIC
// gain constant and the arctangent step table built at elaboration.
// Depends on nothing; imported by vector_axis_rotation_core.
package varot_pkg;

    // Component and angle formats
    localparam int COMP_W    = 32;
    localparam int ANG_W     = 32;
    localparam int GUARD     = 8;
    localparam int ITERS     = ANG_W - 2;
    // Prescaled magnitude stays below 2^(COMP_W+7); CORDIC gain and the
    // vector length add under two more bits, plus sign and margin
    localparam int WORK_W    = COMP_W + 10;
    localparam int KGAIN_W   = 32;
    localparam int PROD_W    = COMP_W + KGAIN_W;
    localparam int PRE_SHIFT = KGAIN_W - GUARD;
    // Pipeline: multiply, prescale, one stage per CORDIC step, output
    localparam int NSTAGE    = ITERS + 3;
    localparam int LAST      = NSTAGE - 1;

    // Gain compensation K = 0.607252935... as an unsigned Q0.32
    localparam logic [KGAIN_W-1:0] KGAIN  = 32'h9B74EDA8;
    localparam logic [63:0]        INV2PI = 64'h28BE60DB9391054A;
    localparam int                 ARC_SH = 62 - ANG_W;

    // Residual angle bound after the last step, in binary angle units
    localparam int RESID_BOUND = 256;

    typedef logic signed [COMP_W-1:0] comp_t;
    typedef logic signed [WORK_W-1:0] work_t;
    typedef logic signed [ANG_W-1:0]  angle_t;
    typedef logic [1:0]               axis_t;
    typedef logic [1:0]               quad_t;

    // Axis codes
    localparam axis_t AXIS_X = 2'd0;
    localparam axis_t AXIS_Y = 2'd1;
    localparam axis_t AXIS_Z = 2'd2;

    // Quarter turns taken out ahead of the CORDIC steps
    localparam quad_t QTR_NONE  = 2'd0;
    localparam quad_t QTR_ONE   = 2'd1;
    localparam quad_t QTR_HALF  = 2'd2;
    localparam quad_t QTR_THREE = 2'd3;

    // atan(2^-i) in Q62 radians by its alternating series
    function automatic logic [63:0] arc_q62(input int i);
        logic [63:0] q62;
        logic [63:0] s;
        q62 = 64'd1 << 62;
        s   = 64'd0;
        if (i * 1  <= 62) s = s + (q62 >> i);
        if (i * 3  <= 62) s = s - ((q62 >> (i * 3)) / 3);
        if (i * 5  <= 62) s = s + ((q62 >> (i * 5)) / 5);
        if (i * 7  <= 62) s = s - ((q62 >> (i * 7)) / 7);
        if (i * 9  <= 62) s = s + ((q62 >> (i * 9)) / 9);
        if (i * 11 <= 62) s = s - ((q62 >> (i * 11)) / 11);
        if (i * 13 <= 62) s = s + ((q62 >> (i * 13)) / 13);
        if (i * 15 <= 62) s = s - ((q62 >> (i * 15)) / 15);
        if (i * 17 <= 62) s = s + ((q62 >> (i * 17)) / 17);
        if (i * 19 <= 62) s = s - ((q62 >> (i * 19)) / 19);
        if (i * 21 <= 62) s = s + ((q62 >> (i * 21)) / 21);
        if (i * 23 <= 62) s = s - ((q62 >> (i * 23)) / 23);
        if (i * 25 <= 62) s = s + ((q62 >> (i * 25)) / 25);
        if (i * 27 <= 62) s = s - ((q62 >> (i * 27)) / 27);
        if (i * 29 <= 62) s = s + ((q62 >> (i * 29)) / 29);
        if (i * 31 <= 62) s = s - ((q62 >> (i * 31)) / 31);
        if (i * 33 <= 62) s = s + ((q62 >> (i * 33)) / 33);
        if (i * 35 <= 62) s = s - ((q62 >> (i * 35)) / 35);
        if (i * 37 <= 62) s = s + ((q62 >> (i * 37)) / 37);
        if (i * 39 <= 62) s = s - ((q62 >> (i * 39)) / 39);
        if (i * 41 <= 62) s = s + ((q62 >> (i * 41)) / 41);
        if (i * 43 <= 62) s = s - ((q62 >> (i * 43)) / 43);
        if (i * 45 <= 62) s = s + ((q62 >> (i * 45)) / 45);
        if (i * 47 <= 62) s = s - ((q62 >> (i * 47)) / 47);
        if (i * 49 <= 62) s = s + ((q62 >> (i * 49)) / 49);
        if (i * 51 <= 62) s = s - ((q62 >> (i * 51)) / 51);
        if (i * 53 <= 62) s = s + ((q62 >> (i * 53)) / 53);
        if (i * 55 <= 62) s = s - ((q62 >> (i * 55)) / 55);
        if (i * 57 <= 62) s = s + ((q62 >> (i * 57)) / 57);
        if (i * 59 <= 62) s = s - ((q62 >> (i * 59)) / 59);
        if (i * 61 <= 62) s = s + ((q62 >> (i * 61)) / 61);
        return s;
    endfunction

    // Step angle i in binary angle units, rounded half up
    function automatic logic [ANG_W-1:0] arc_step(input int i);
        logic [127:0] prod;
        logic [63:0]  turns;
        logic [63:0]  rnd;
        prod  = {64'd0, arc_q62(i)} * {64'd0, INV2PI};
        turns = prod[127:64];
        rnd   = (turns + (64'd1 << (ARC_SH - 1))) >> ARC_SH;
        if (i == 0)
        begin
            rnd = 64'd1 << (ANG_W - 3);
        end
        return rnd[ANG_W-1:0];
    endfunction

    function automatic logic [ITERS-1:0][ANG_W-1:0] arc_steps();
        logic [ITERS-1:0][ANG_W-1:0] t;
        for (int i = 0; i < ITERS; i++)
        begin
            t[i] = arc_step(i);
        end
        return t;
    endfunction

    localparam logic [ITERS-1:0][ANG_W-1:0] ARC_TAB = arc_steps();

endpackage

// ===== src/vector_axis_rotation_core.sv =====
// Each vector passes through 33 register stages: gain multiply, prescale and quarter turn,
// 30 CORDIC steps, round and saturate.
// Throughput: one vector per cycle; each stage holds one item and a stalled
// result blocks only the stages behind it that are full.
// Reset clears the stage valid bits only; the core needs no warm-up.
//
// Vector rotation about the x, y or z axis with a gain-compensated CORDIC.
// Depends on varot_pkg.
module vector_axis_rotation_core
    import varot_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    // item channel
    input  logic                     item_valid,
    output logic                     item_stall,
    input  logic [1:0]               op,
    input  logic signed [COMP_W-1:0] vec_x,
    input  logic signed [COMP_W-1:0] vec_y,
    input  logic signed [COMP_W-1:0] vec_z,
    input  logic signed [ANG_W-1:0]  turn_angle,
    // result channel
    output logic                     result_valid,
    input  logic                     result_stall,
    output logic signed [COMP_W-1:0] out_x,
    output logic signed [COMP_W-1:0] out_y,
    output logic signed [COMP_W-1:0] out_z
);

    // Stage control
    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] valid_next;
    logic [NSTAGE:0]   ready;

    // Fields carried down the pipe
    axis_t  axis_reg  [0:LAST-1];
    axis_t  axis_next [0:LAST-1];
    comp_t  vx_reg    [0:LAST-1];
    comp_t  vx_next   [0:LAST-1];
    comp_t  vy_reg    [0:LAST-1];
    comp_t  vy_next   [0:LAST-1];
    comp_t  vz_reg    [0:LAST-1];
    comp_t  vz_next   [0:LAST-1];
    angle_t resid_reg [0:LAST-1];
    angle_t resid_next[0:LAST-1];

    // Multiply stage
    logic [PROD_W-1:0] prod_a_reg;
    logic [PROD_W-1:0] prod_a_next;
    logic [PROD_W-1:0] prod_b_reg;
    logic [PROD_W-1:0] prod_b_next;
    logic              neg_a_reg;
    logic              neg_a_next;
    logic              neg_b_reg;
    logic              neg_b_next;
    quad_t             quad_reg;
    quad_t             quad_next;

    // CORDIC pair
    work_t cx_reg [1:LAST-1];
    work_t cx_next[1:LAST-1];
    work_t cy_reg [1:LAST-1];
    work_t cy_next[1:LAST-1];

    // Output register
    comp_t out_x_reg;
    comp_t out_x_next;
    comp_t out_y_reg;
    comp_t out_y_next;
    comp_t out_z_reg;
    comp_t out_z_next;

    // Front-end working values
    comp_t              pair_a;
    comp_t              pair_b;
    logic [COMP_W-1:0]  mag_a;
    logic [COMP_W-1:0]  mag_b;
    logic [ANG_W-1:0]   phi;
    logic [ANG_W-1:0]   phi_ofs;
    logic [PROD_W-1:0]  rsum_a;
    logic [PROD_W-1:0]  rsum_b;
    work_t              ra;
    work_t              rb;
    work_t              pick_x;
    work_t              pick_y;
    logic               flip_x;
    logic               flip_y;
    comp_t              fin_x;
    comp_t              fin_y;

    // Round off the guard bits and clamp to the component range
    function automatic comp_t finish(input work_t v);
        work_t                     t;
        logic [WORK_W-GUARD-1:0]   r;
        comp_t                     res;
        t = v + work_t'(1 << (GUARD - 1));
        r = t[WORK_W-1:GUARD];
        if (r[WORK_W-GUARD-1:COMP_W-1] == '0 || r[WORK_W-GUARD-1:COMP_W-1] == '1)
        begin
            res = r[COMP_W-1:0];
        end
        else if (r[WORK_W-GUARD-1])
        begin
            res = {1'b1, {(COMP_W-1){1'b0}}};
        end
        else
        begin
            res = {1'b0, {(COMP_W-1){1'b1}}};
        end
        return res;
    endfunction

    // Stall chain: a stage moves when it is empty or the one after it moves
    always_comb
    begin
        ready[NSTAGE] = !result_stall;
        for (int k = NSTAGE - 1; k >= 0; k--)
        begin
            ready[k] = !valid_reg[k] || ready[k+1];
        end
    end

    assign item_stall = !ready[0];

    // Advance valid bits with the data
    always_comb
    begin
        for (int k = 0; k < NSTAGE; k++)
        begin
            if (!ready[k])
            begin
                valid_next[k] = valid_reg[k];
            end
            else if (k == 0)
            begin
                valid_next[k] = item_valid;
            end
            else
            begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    // Stage 0: pick the pair, take magnitudes, multiply by the gain, split off quarter turns
    always_comb
    begin
        case (op)
            AXIS_X:
            begin
                pair_a = vec_y;
                pair_b = vec_z;
            end
            AXIS_Y:
            begin
                pair_a = vec_z;
                pair_b = vec_x;
            end
            AXIS_Z:
            begin
                pair_a = vec_x;
                pair_b = vec_y;
            end
            default:
            begin
                pair_a = vec_x;
                pair_b = vec_y;
            end
        endcase
        mag_a       = pair_a[COMP_W-1] ? (~pair_a + 1'b1) : pair_a;
        mag_b       = pair_b[COMP_W-1] ? (~pair_b + 1'b1) : pair_b;
        prod_a_next = PROD_W'(mag_a) * PROD_W'(KGAIN);
        prod_b_next = PROD_W'(mag_b) * PROD_W'(KGAIN);
        neg_a_next  = pair_a[COMP_W-1];
        neg_b_next  = pair_b[COMP_W-1];

        phi         = '0 - turn_angle;
        phi_ofs     = phi + (ANG_W'(1) << (ANG_W - 3));
        quad_next   = phi_ofs[ANG_W-1 -: 2];
    end

    // Stage 1: round the prescaled magnitudes, pick signs and operands for the quarter turn
    always_comb
    begin
        rsum_a = prod_a_reg + (PROD_W'(1) << (PRE_SHIFT - 1));
        rsum_b = prod_b_reg + (PROD_W'(1) << (PRE_SHIFT - 1));
        ra     = WORK_W'(rsum_a >> PRE_SHIFT);
        rb     = WORK_W'(rsum_b >> PRE_SHIFT);
        case (quad_reg)
            QTR_NONE:
            begin
                pick_x = ra;
                flip_x = neg_a_reg;
                pick_y = rb;
                flip_y = neg_b_reg;
            end
            QTR_ONE:
            begin
                pick_x = rb;
                flip_x = !neg_b_reg;
                pick_y = ra;
                flip_y = neg_a_reg;
            end
            QTR_HALF:
            begin
                pick_x = ra;
                flip_x = !neg_a_reg;
                pick_y = rb;
                flip_y = !neg_b_reg;
            end
            QTR_THREE:
            begin
                pick_x = rb;
                flip_x = neg_b_reg;
                pick_y = ra;
                flip_y = !neg_a_reg;
            end
            default:
            begin
                pick_x = ra;
                flip_x = neg_a_reg;
                pick_y = rb;
                flip_y = neg_b_reg;
            end
        endcase
    end

    // Residual and pair: take the quarter turn out, apply signs, then drive the
    // residual angle toward zero, one CORDIC step per stage
    always_comb
    begin
        resid_next[0] = phi - {quad_next, {(ANG_W-2){1'b0}}};
        cx_next[1]    = flip_x ? -pick_x : pick_x;
        cy_next[1]    = flip_y ? -pick_y : pick_y;
        resid_next[1] = resid_reg[0];
        for (int i = 0; i < ITERS; i++)
        begin
            if (!resid_reg[i+1][ANG_W-1])
            begin
                cx_next[i+2]    = cx_reg[i+1] - (cy_reg[i+1] >>> i);
                cy_next[i+2]    = cy_reg[i+1] + (cx_reg[i+1] >>> i);
                resid_next[i+2] = resid_reg[i+1] - angle_t'(ARC_TAB[i]);
            end
            else
            begin
                cx_next[i+2]    = cx_reg[i+1] + (cy_reg[i+1] >>> i);
                cy_next[i+2]    = cy_reg[i+1] - (cx_reg[i+1] >>> i);
                resid_next[i+2] = resid_reg[i+1] + angle_t'(ARC_TAB[i]);
            end
        end
    end

    // Pass axis code and the raw vector alongside
    always_comb
    begin
        axis_next[0] = op;
        vx_next[0]   = vec_x;
        vy_next[0]   = vec_y;
        vz_next[0]   = vec_z;
        for (int k = 1; k < LAST; k++)
        begin
            axis_next[k] = axis_reg[k-1];
            vx_next[k]   = vx_reg[k-1];
            vy_next[k]   = vy_reg[k-1];
            vz_next[k]   = vz_reg[k-1];
        end
    end

    // Output stage: round, saturate and put the pair back in place
    always_comb
    begin
        fin_x = finish(cx_reg[LAST-1]);
        fin_y = finish(cy_reg[LAST-1]);
        case (axis_reg[LAST-1])
            AXIS_X:
            begin
                out_x_next = vx_reg[LAST-1];
                out_y_next = fin_x;
                out_z_next = fin_y;
            end
            AXIS_Y:
            begin
                out_x_next = fin_y;
                out_y_next = vy_reg[LAST-1];
                out_z_next = fin_x;
            end
            AXIS_Z:
            begin
                out_x_next = fin_x;
                out_y_next = fin_y;
                out_z_next = vz_reg[LAST-1];
            end
            default:
            begin
                out_x_next = vx_reg[LAST-1];
                out_y_next = vy_reg[LAST-1];
                out_z_next = vz_reg[LAST-1];
            end
        endcase
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload: load a stage whenever it moves
    always_ff @(posedge clk)
    begin
        if (ready[0])
        begin
            prod_a_reg <= prod_a_next;
            prod_b_reg <= prod_b_next;
            neg_a_reg  <= neg_a_next;
            neg_b_reg  <= neg_b_next;
            quad_reg   <= quad_next;
        end
        for (int k = 0; k < LAST; k++)
        begin
            if (ready[k])
            begin
                axis_reg[k]  <= axis_next[k];
                vx_reg[k]    <= vx_next[k];
                vy_reg[k]    <= vy_next[k];
                vz_reg[k]    <= vz_next[k];
                resid_reg[k] <= resid_next[k];
            end
        end
        for (int k = 1; k < LAST; k++)
        begin
            if (ready[k])
            begin
                cx_reg[k] <= cx_next[k];
                cy_reg[k] <= cy_next[k];
            end
        end
        if (ready[LAST])
        begin
            out_x_reg <= out_x_next;
            out_y_reg <= out_y_next;
            out_z_reg <= out_z_next;
        end
    end

    assign result_valid = valid_reg[LAST];
    assign out_x        = out_x_reg;
    assign out_y        = out_y_reg;
    assign out_z        = out_z_reg;

    // An input transfer fills stage 0 on the next edge
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> valid_reg[0])
        else $error("accepted item did not enter stage 0");

    // The input backs up only when every stage is full and the result is held
    assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (&valid_reg) && result_stall)
        else $error("input stalled with room in the pipe");

    // A free result side always lets an item in
    assert property (@(posedge clk) disable iff (!rst_n)
        !result_stall |-> !item_stall)
        else $error("input stalled while output is free");

    // The residual angle has converged by the last CORDIC step
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[LAST-1] |->
            resid_reg[LAST-1] <= angle_t'(RESID_BOUND) &&
            resid_reg[LAST-1] >= -angle_t'(RESID_BOUND))
        else $error("CORDIC residual did not converge");

endmodule
